/* design/spq_pkg.sv */
// Shared constants, codes and types for the sorted priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int PRIO_WIDTH  = 16;
  localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  // Operation codes carried by a request
  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_DRAIN = 2'd3
  } op_t;

  // Status codes of a result
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the new entry, shifting lower entries towards the tail
    logic rem;  // remove the head, shifting every entry towards the head
  } cell_ctrl_t;

endpackage

/* design/sorted_priority_queue_core.sv */
// Sorted priority queue: a chain of slot cells with a small controller and output register.
//
// Bounded priority queue of spq_pkg::QUEUE_DEPTH entries held in a chain of cells,
// highest priority at the head, equal priorities served in arrival order. Enqueue,
// dequeue and peek are each done on acceptance: every cell compares its priority with the
// new one in parallel and the chain shifts by one slot. A drain of an empty queue
// gives a single empty result; a drain of a non-empty queue has an accepting step,
// a step per entry as the chain moves it to the head, and a closing step that emits
// the final word; all-zero words are not emitted. A stalled output holds the drain. Each result
// passes through an output register, and a request is taken only when that register
// is empty or its result leaves in the same cycle; no new request is taken during a
// drain. Slot contents need no clearing after reset.
module sorted_priority_queue_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [1:0]                     op,
  input  logic        [spq_pkg::DATA_WIDTH-1:0] item_data,
  input  logic signed [spq_pkg::PRIO_WIDTH-1:0] item_priority,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [spq_pkg::DATA_WIDTH-1:0] result_data,
  output logic                                  found,
  output logic        [1:0]                     status,
  output logic        [spq_pkg::COUNT_WIDTH-1:0] entry_count,
  output logic                                  last
);

  localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
  localparam int DW    = spq_pkg::DATA_WIDTH;
  localparam int PW    = spq_pkg::PRIO_WIDTH;
  localparam int CW    = spq_pkg::COUNT_WIDTH;

  spq_pkg::state_t     state;
  logic [CW-1:0]       occupancy;
  logic [CW-1:0]       remaining;
  logic [CW-1:0]       emitted;
  logic                pend_valid;
  logic [DW-1:0]       pend_data;

  spq_pkg::cell_ctrl_t ctrl;
  logic [DW-1:0]        cell_data [DEPTH];
  logic signed [PW-1:0] cell_prio [DEPTH];
  logic [DEPTH-1:0]     cell_ge;

  logic in_acc, out_free, full, in_drain;
  logic drain_shift, drain_mid, drain_finish, out_load;
  logic [DW-1:0]        ld_data;
  logic                 ld_found;
  spq_pkg::status_t     ld_status;
  logic [CW-1:0]        ld_count;
  logic                 ld_last;

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != spq_pkg::S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign full     = (occupancy == CW'(DEPTH));
  assign in_drain = (state == spq_pkg::S_DRAIN);

  // Drain: one slot per cycle unless a held word waits, one non-zero word held back
  assign drain_shift  = in_drain && (remaining != '0) &&
                        ((cell_data[0] == '0) || !pend_valid || out_free);
  assign drain_mid    = in_drain && (remaining != '0) && (cell_data[0] != '0) &&
                        pend_valid && out_free;
  assign drain_finish = in_drain && (remaining == '0) && out_free;

  // Chain commands
  assign ctrl.ins = in_acc && (op == spq_pkg::OP_ENQ) && !full;
  assign ctrl.rem = (in_acc && (op == spq_pkg::OP_DEQ) && (occupancy != '0)) || drain_shift;

  // Build the chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_ge;
    logic [DW-1:0]        l_data, r_data;
    logic signed [PW-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      assign l_ge   = 1'b1;
      assign l_data = '0;
      assign l_prio = '0;
    end else begin : g_body
      assign l_ge   = cell_ge[i-1];
      assign l_data = cell_data[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_data = '0;
      assign r_prio = '0;
    end else begin : g_inner
      assign r_data = cell_data[i+1];
      assign r_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CW'(i) < occupancy),
      .new_data   (item_data),
      .new_prio   (item_priority),
      .left_ge    (l_ge),
      .left_data  (l_data),
      .left_prio  (l_prio),
      .right_data (r_data),
      .right_prio (r_prio),
      .data       (cell_data[i]),
      .prio       (cell_prio[i]),
      .ge         (cell_ge[i])
    );
  end

  // Select the result to load into the output register
  always_comb begin
    out_load  = 1'b0;
    ld_data   = '0;
    ld_found  = 1'b0;
    ld_status = spq_pkg::ST_OK;
    ld_count  = occupancy;
    ld_last   = 1'b1;
    if (drain_mid) begin
      out_load = 1'b1;
      ld_data  = pend_data;
      ld_found = 1'b1;
      ld_count = emitted + CW'(1);
      ld_last  = 1'b0;
    end else if (drain_finish) begin
      out_load = 1'b1;
      if (pend_valid) begin
        ld_data  = pend_data;
        ld_found = 1'b1;
        ld_count = emitted + CW'(1);
      end else begin
        ld_count = '0;
      end
    end else if (in_acc) begin
      unique case (op) inside
        spq_pkg::OP_ENQ: begin
          out_load = 1'b1;
          if (full) begin
            ld_status = spq_pkg::ST_FULL;
          end else begin
            ld_count = occupancy + CW'(1);
          end
        end
        spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
          out_load = 1'b1;
          if (occupancy == '0) begin
            ld_status = spq_pkg::ST_EMPTY;
          end else begin
            ld_data  = cell_data[0];
            ld_found = 1'b1;
            if (op == spq_pkg::OP_DEQ) begin
              ld_count = occupancy - CW'(1);
            end
          end
        end
        spq_pkg::OP_DRAIN: begin
          if (occupancy == '0) begin
            out_load  = 1'b1;
            ld_status = spq_pkg::ST_EMPTY;
          end
        end
        default: out_load = 1'b0;
      endcase
    end
  end

  // Controller state, occupancy and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= spq_pkg::S_IDLE;
      occupancy  <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      remaining  <= '0;
      emitted    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctrl.ins) begin
        occupancy <= occupancy + CW'(1);
      end
      unique case (state)
        spq_pkg::S_IDLE: begin
          if (in_acc && (op == spq_pkg::OP_DEQ) && (occupancy != '0)) begin
            occupancy <= occupancy - CW'(1);
          end
          if (in_acc && (op == spq_pkg::OP_DRAIN) && (occupancy != '0)) begin
            state      <= spq_pkg::S_DRAIN;
            remaining  <= occupancy;
            emitted    <= '0;
            pend_valid <= 1'b0;
          end
        end
        spq_pkg::S_DRAIN: begin
          if (drain_shift) begin
            remaining <= remaining - CW'(1);
            if (cell_data[0] != '0) begin
              pend_valid <= 1'b1;
            end
          end
          if (drain_mid) begin
            emitted <= emitted + CW'(1);
          end
          if (drain_finish) begin
            state      <= spq_pkg::S_IDLE;
            occupancy  <= '0;
            pend_valid <= 1'b0;
          end
        end
        default: state <= spq_pkg::S_IDLE;
      endcase
    end
  end

  // Capture the held-back drain word
  always_ff @(posedge clk) begin
    if (drain_shift && (cell_data[0] != '0)) begin
      pend_data <= cell_data[0];
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_data <= ld_data;
      found       <= ld_found;
      status      <= ld_status;
      entry_count <= ld_count;
      last        <= ld_last;
    end
  end

  // Occupancy never exceeds the chain length
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(DEPTH))
    else $error("occupancy beyond queue depth");

  // No request is taken while a drain is running
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    in_drain |-> in_stall)
    else $error("request accepted during drain");

  // An accepted enqueue into a non-full queue grows it by one
  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (op == spq_pkg::OP_ENQ) && !full) |=>
      (occupancy == $past(occupancy) + CW'(1)))
    else $error("enqueue did not grow occupancy");

  // The end of a drain leaves the queue empty
  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    drain_finish |=> ((occupancy == '0) && (state == spq_pkg::S_IDLE)))
    else $error("drain did not empty the queue");

  // A drain never emits mid-sequence and finishes in the same cycle
  a_drain_excl: assert property (@(posedge clk) disable iff (rst)
    !(drain_mid && drain_finish))
    else $error("drain emitted twice in one cycle");

endmodule

/* design/spq_cell.sv */
// One slot of the sorted chain: holds an entry and trades it with its neighbours.
module spq_cell (
  input  logic                                   clk,
  input  spq_pkg::cell_ctrl_t                    ctrl,
  input  logic                                   occupied,
  input  logic        [spq_pkg::DATA_WIDTH-1:0]  new_data,
  input  logic signed [spq_pkg::PRIO_WIDTH-1:0]  new_prio,
  input  logic                                   left_ge,
  input  logic        [spq_pkg::DATA_WIDTH-1:0]  left_data,
  input  logic signed [spq_pkg::PRIO_WIDTH-1:0]  left_prio,
  input  logic        [spq_pkg::DATA_WIDTH-1:0]  right_data,
  input  logic signed [spq_pkg::PRIO_WIDTH-1:0]  right_prio,
  output logic        [spq_pkg::DATA_WIDTH-1:0]  data,
  output logic signed [spq_pkg::PRIO_WIDTH-1:0]  prio,
  output logic                                   ge
);

  // Keep this entry ahead of the new one when its priority is not lower
  assign ge = occupied && (prio >= new_prio);

  // Hold, take the new entry, take the left entry, or take the right entry
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!ge) begin
        if (left_ge) begin
          data <= new_data;
          prio <= new_prio;
        end else begin
          data <= left_data;
          prio <= left_prio;
        end
      end
    end else if (ctrl.rem) begin
      data <= right_data;
      prio <= right_prio;
    end
  end

endmodule

/* tb/tb_sorted_priority_queue_core.sv */
// Testbench for the sorted priority queue core: random requests checked against a shadow queue.

typedef struct packed {
  logic [spq_pkg::DATA_WIDTH-1:0]  data;
  logic                            found;
  logic [1:0]                      status;
  logic [spq_pkg::COUNT_WIDTH-1:0] count;
  logic                            last;
} pq_result_t;

// Shadow copy of the queue plus the results still owed by the block
class pq_scoreboard;
  logic        [spq_pkg::DATA_WIDTH-1:0] held_data[spq_pkg::QUEUE_DEPTH];
  logic signed [spq_pkg::PRIO_WIDTH-1:0] held_prio[spq_pkg::QUEUE_DEPTH];
  int          held_count;
  pq_result_t  owed[$];
  int unsigned mismatches;

  function new();
    held_count = 0;
    mismatches = 0;
  endfunction

  function void owe(logic [spq_pkg::DATA_WIDTH-1:0] d, logic f, logic [1:0] st, int cnt,
                    logic lst);
    pq_result_t r;
    r.data   = d;
    r.found  = f;
    r.status = st;
    r.count  = cnt[spq_pkg::COUNT_WIDTH-1:0];
    r.last   = lst;
    owed.push_back(r);
  endfunction

  // Apply an accepted request to the shadow queue and note what it must produce
  function void note_request(spq_pkg::op_t o, logic [spq_pkg::DATA_WIDTH-1:0] d,
                             logic signed [spq_pkg::PRIO_WIDTH-1:0] p);
    int pos;
    int i;
    int emitted;
    logic [spq_pkg::DATA_WIDTH-1:0] head;
    case (o) inside
      spq_pkg::OP_ENQ: begin
        if (held_count >= spq_pkg::QUEUE_DEPTH) begin
          owe('0, 1'b0, spq_pkg::ST_FULL, held_count, 1'b1);
        end else begin
          // go behind every entry of greater or equal priority
          pos = 0;
          while (pos < held_count && held_prio[pos] >= p) pos++;
          for (i = held_count; i > pos; i--) begin
            held_data[i] = held_data[i-1];
            held_prio[i] = held_prio[i-1];
          end
          held_data[pos] = d;
          held_prio[pos] = p;
          held_count++;
          owe('0, 1'b0, spq_pkg::ST_OK, held_count, 1'b1);
        end
      end
      spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
        if (held_count == 0) begin
          owe('0, 1'b0, spq_pkg::ST_EMPTY, 0, 1'b1);
        end else begin
          head = held_data[0];
          if (o == spq_pkg::OP_DEQ) begin
            for (i = 1; i < held_count; i++) begin
              held_data[i-1] = held_data[i];
              held_prio[i-1] = held_prio[i];
            end
            held_count--;
          end
          owe(head, 1'b1, spq_pkg::ST_OK, held_count, 1'b1);
        end
      end
      default: begin
        // drain: skip null words, flag the final one
        emitted = 0;
        for (i = 0; i < held_count; i++) begin
          if (held_data[i] != '0) begin
            emitted++;
            owe(held_data[i], 1'b1, spq_pkg::ST_OK, emitted, 1'b0);
          end
        end
        if (emitted == 0) begin
          owe('0, 1'b0, (held_count == 0) ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK,
              0, 1'b1);
        end else begin
          owed[$].last = 1'b1;
        end
        held_count = 0;
      end
    endcase
  endfunction

  // Compare an accepted result with the oldest one owed
  function void check_result(logic [spq_pkg::DATA_WIDTH-1:0] d, logic f, logic [1:0] st,
                             logic [spq_pkg::COUNT_WIDTH-1:0] cnt, logic lst);
    pq_result_t want;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: data=%h found=%b status=%0d count=%0d last=%b",
                 d, f, st, cnt, lst);
    end else begin
      want = owed.pop_front();
      if (d !== want.data || f !== want.found || st !== want.status ||
          cnt !== want.count || lst !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected data=%h found=%b status=%0d count=%0d last=%b,",
                    " got data=%h found=%b status=%0d count=%0d last=%b"},
                   want.data, want.found, want.status, want.count, want.last,
                   d, f, st, cnt, lst);
      end
    end
  endfunction
endclass

module tb_sorted_priority_queue_core;

  localparam int RANDOM_ITEMS = 160;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int SETTLE       = 40;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  logic [1:0]                             op = spq_pkg::OP_PEEK;
  logic [spq_pkg::DATA_WIDTH-1:0]         item_data = '0;
  logic signed [spq_pkg::PRIO_WIDTH-1:0]  item_priority = '0;
  logic                                   out_valid;
  logic                                   out_stall = 1'b0;
  logic [spq_pkg::DATA_WIDTH-1:0]         result_data;
  logic                                   found;
  logic [1:0]                             status;
  logic [spq_pkg::COUNT_WIDTH-1:0]        entry_count;
  logic                                   last;

  int unsigned idle_pct = 33;
  int unsigned cycle_count = 0;
  int unsigned random_sent;
  pq_scoreboard board;

  sorted_priority_queue_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .item_data     (item_data),
    .item_priority (item_priority),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_data   (result_data),
    .found         (found),
    .status        (status),
    .entry_count   (entry_count),
    .last          (last)
  );

  always #5 clk = ~clk;

  // Count cycles for the timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Note accepted requests before checking results seen at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        board.note_request(spq_pkg::op_t'(op), item_data, item_priority);
      if (out_valid && !out_stall)
        board.check_result(result_data, found, status, entry_count, last);
    end
  end

  // Offer one request, idling at random first, and hold it until taken
  task automatic send_request(input spq_pkg::op_t o,
                              input logic [spq_pkg::DATA_WIDTH-1:0] d,
                              input logic signed [spq_pkg::PRIO_WIDTH-1:0] p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= o;
    item_data     <= d;
    item_priority <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly a narrow band so that ties are common, sometimes extremes or anything
  function automatic logic signed [spq_pkg::PRIO_WIDTH-1:0] pick_priority();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 6) return spq_pkg::PRIO_WIDTH'($signed($urandom_range(8)) - 4);
    if (roll == 6) return $urandom_range(1) ? {1'b1, {(spq_pkg::PRIO_WIDTH-1){1'b0}}}
                                            : {1'b0, {(spq_pkg::PRIO_WIDTH-1){1'b1}}};
    return spq_pkg::PRIO_WIDTH'($urandom);
  endfunction

  function automatic logic [spq_pkg::DATA_WIDTH-1:0] pick_data();
    int unsigned roll;
    roll = $urandom_range(15);
    if (roll < 2) return '0;
    if (roll == 2) return '1;
    return $urandom;
  endfunction

  task automatic send_random(input spq_pkg::op_t o);
    send_request(o, pick_data(), pick_priority());
    random_sent++;
  endtask

  initial begin
    int n;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, extremes, ties, null words, drain of nulls only
    send_request(spq_pkg::OP_DEQ, 32'h1234_5678, 16'sd0);
    send_request(spq_pkg::OP_PEEK, '0, 16'sd0);
    send_request(spq_pkg::OP_DRAIN, '0, 16'sd0);
    send_request(spq_pkg::OP_ENQ, 32'hFFFF_FFFF, -16'sd32768);
    send_request(spq_pkg::OP_ENQ, 32'h0000_0001, 16'sd32767);
    send_request(spq_pkg::OP_ENQ, 32'h0000_0000, 16'sd0);
    send_request(spq_pkg::OP_ENQ, 32'hAAAA_AAAA, 16'sd5);
    send_request(spq_pkg::OP_ENQ, 32'h5555_5555, 16'sd5);
    send_request(spq_pkg::OP_ENQ, 32'hC0DE_0001, -16'sd1);
    send_request(spq_pkg::OP_PEEK, '0, 16'sd0);
    send_request(spq_pkg::OP_DEQ, '0, 16'sd0);
    send_request(spq_pkg::OP_DRAIN, '0, 16'sd0);
    send_request(spq_pkg::OP_ENQ, 32'h0000_0000, 16'sd3);
    send_request(spq_pkg::OP_ENQ, 32'h0000_0000, -16'sd3);
    send_request(spq_pkg::OP_DRAIN, '0, 16'sd0);
    send_request(spq_pkg::OP_ENQ, 32'h0000_0000, 16'sd0);
    send_request(spq_pkg::OP_DEQ, '0, 16'sd0);
    send_request(spq_pkg::OP_DEQ, '0, 16'sd0);

    // Random bursts: fills past full, runs of dequeue and peek, drains, noise
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      idle_pct = (random_sent >= 60 && random_sent < 110) ? 0 : 33;
      case ($urandom_range(9)) inside
        [0:3]: begin
          n = $urandom_range(4, 20);
          repeat (n) send_random(spq_pkg::OP_ENQ);
        end
        [4:5]: begin
          n = $urandom_range(1, 18);
          repeat (n) send_random(($urandom_range(9) < 7) ? spq_pkg::OP_DEQ
                                                         : spq_pkg::OP_PEEK);
        end
        [6:7]: send_random(spq_pkg::OP_DRAIN);
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) send_random(spq_pkg::op_t'($urandom_range(3)));
        end
      endcase
    end
    in_valid <= 1'b0;
    idle_pct = 33;

    // Let every owed result arrive, then watch for strays
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("sorted_priority_queue_core test passed");
    end else begin
      $display("sorted_priority_queue_core test failed");
    end
    $finish;
  end

  // End a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("sorted_priority_queue_core test failed");
    $finish;
  end

endmodule
